/* design/dws_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dws_pkg: shared types and constants of the deque with search
// Sizes, command and status codes, state encoding and the control bundles
// that pass between the top level, the cell chain and the finder.
// ----------------------------------------------------------------------------
package dws_pkg;

  // Storage size and derived widths
  localparam int DEPTH  = 64;
  localparam int KEY_W  = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CH     = 8;
  localparam int CH_W   = $clog2(CH);
  localparam int NCHUNK = (DEPTH + CH - 1) / CH;
  localparam int CHK_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int PAD_N  = (2 ** CHK_W) * CH;
  localparam int PAD_W  = CHK_W + CH_W;

  // Fixed port field widths
  localparam int CMD_W = 3;
  localparam int STS_W = 2;
  localparam int POS_W = 7;
  localparam int OCC_W = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_L = 3'd0,
    CMD_PUSH_R = 3'd1,
    CMD_POP_L  = 3'd2,
    CMD_POP_R  = 3'd3,
    CMD_SEARCH = 3'd4
  } cmd_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2
  } sts_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  // Per-cycle control broadcast to every cell
  typedef struct packed {
    logic push_l;   // take the left neighbor's key
    logic pop_l;    // take the right neighbor's key
    logic push_r;   // the cell at the tail takes the new key
    logic hit_load; // capture a hit flag
    logic hit_srch; // hit means key match, otherwise "last held entry"
  } cell_ctrl_t;

  // Finder control and result
  typedef struct packed {
    logic clr;
    logic step;
  } fnd_ctrl_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] pos;
    logic [KEY_W-1:0] val;
  } fnd_res_t;

endpackage

/* design/dws_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dws_cell: one storage cell of the deque chain
// Holds one key and one hit flag. Shifts with its neighbors on left pushes
// and pops, loads the new key at the tail, flags a match or the last entry.
// ----------------------------------------------------------------------------
module dws_cell (
  input  logic                     clk,
  input  dws_pkg::cell_ctrl_t      ctrl,
  input  logic [dws_pkg::CNT_W-1:0] idx,
  input  logic [dws_pkg::CNT_W-1:0] cnt,
  input  logic [dws_pkg::KEY_W-1:0] key,
  input  logic [dws_pkg::KEY_W-1:0] cmp_key,
  input  logic [dws_pkg::KEY_W-1:0] left_val,
  input  logic [dws_pkg::KEY_W-1:0] right_val,
  output logic [dws_pkg::KEY_W-1:0] val,
  output logic                      hit
);
  import dws_pkg::*;

  logic [KEY_W-1:0] val_r, val_nxt;
  logic             hit_r, hit_nxt;
  logic             in_use;
  logic             is_last;

  assign in_use  = (idx < cnt);
  assign is_last = (({1'b0, idx} + 1'b1) == {1'b0, cnt});

  // Select the next key
  always_comb begin
    val_nxt = val_r;
    if (ctrl.push_l) begin
      val_nxt = left_val;
    end else if (ctrl.pop_l) begin
      val_nxt = right_val;
    end else if (ctrl.push_r && (idx == cnt)) begin
      val_nxt = key;
    end
  end

  // Capture the hit flag
  always_comb begin
    hit_nxt = hit_r;
    if (ctrl.hit_load) begin
      hit_nxt = ctrl.hit_srch ? (in_use && (val_r == cmp_key)) : is_last;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    hit_r <= hit_nxt;
  end

  assign val = val_r;
  assign hit = hit_r;

endmodule

/* design/dws_chain.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dws_chain: row of deque cells
// Wires each cell to its left and right neighbors; entry 0 is the left end.
// ----------------------------------------------------------------------------
module dws_chain (
  input  logic                      clk,
  input  dws_pkg::cell_ctrl_t       ctrl,
  input  logic [dws_pkg::CNT_W-1:0] cnt,
  input  logic [dws_pkg::KEY_W-1:0] key,
  input  logic [dws_pkg::KEY_W-1:0] cmp_key,
  output logic [dws_pkg::KEY_W-1:0] vals [dws_pkg::DEPTH],
  output logic [dws_pkg::DEPTH-1:0] hits
);
  import dws_pkg::*;

  logic [KEY_W-1:0] left_w  [DEPTH];
  logic [KEY_W-1:0] right_w [DEPTH];

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      // Feed the new key into the left end, hold the right end on pops
      if (i == 0) begin : g_first
        assign left_w[i] = key;
      end else begin : g_mid_l
        assign left_w[i] = vals[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
        assign right_w[i] = vals[i];
      end else begin : g_mid_r
        assign right_w[i] = vals[i+1];
      end

      dws_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .idx       (CNT_W'(i)),
        .cnt       (cnt),
        .key       (key),
        .cmp_key   (cmp_key),
        .left_val  (left_w[i]),
        .right_val (right_w[i]),
        .val       (vals[i]),
        .hit       (hits[i])
      );
    end
  endgenerate

endmodule

/* design/dws_finder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dws_finder: first-hit scanner over the cell hit flags
// Walks the hit flags one chunk per cycle from the left end while stepped and
// reports the 1-based position and key of the first flagged cell.
// ----------------------------------------------------------------------------
module dws_finder (
  input  logic                      clk,
  input  logic                      rst_n,
  input  dws_pkg::fnd_ctrl_t        ctrl,
  input  logic [dws_pkg::KEY_W-1:0] vals [dws_pkg::DEPTH],
  input  logic [dws_pkg::DEPTH-1:0] hits,
  output dws_pkg::fnd_res_t         res
);
  import dws_pkg::*;

  logic [CHK_W-1:0] chk_r, chk_nxt;
  logic [KEY_W-1:0] vals_pad [PAD_N];
  logic [PAD_N-1:0] hits_pad;
  logic [CH-1:0]    bits;
  logic [CH_W-1:0]  sel_j;
  logic             any;
  logic [PAD_W-1:0] sel_idx;

  // Pad flags and keys up to a whole number of chunks
  always_comb begin
    hits_pad = '0;
    hits_pad[DEPTH-1:0] = hits;
    for (int k = 0; k < PAD_N; k++) begin
      vals_pad[k] = (k < DEPTH) ? vals[k] : '0;
    end
  end

  // Pick the lowest flagged bit of the current chunk
  always_comb begin
    bits  = hits_pad[{chk_r, {CH_W{1'b0}}} +: CH];
    sel_j = '0;
    any   = 1'b0;
    for (int j = CH - 1; j >= 0; j--) begin
      if (bits[j]) begin
        sel_j = CH_W'(j);
        any   = 1'b1;
      end
    end
    sel_idx = {chk_r, sel_j};
  end

  always_comb begin
    res.done = any || (chk_r == CHK_W'(NCHUNK - 1));
    res.pos  = any ? (CNT_W'(sel_idx) + 1'b1) : '0;
    res.val  = vals_pad[sel_idx];
  end

  // Advance the chunk pointer
  always_comb begin
    chk_nxt = chk_r;
    if (ctrl.clr) begin
      chk_nxt = '0;
    end else if (ctrl.step && !res.done) begin
      chk_nxt = chk_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_r <= '0;
    end else begin
      chk_r <= chk_nxt;
    end
  end

endmodule

/* design/deque_with_search.sv */
`timescale 1ns / 1ps
// Flow: pushes, left pops and unused codes load their result into the output
//   register if free, else wait in S_DONE; a search or non-empty right pop
//   passes S_CMP and S_SCAN, one chunk of eight cells per cycle, and in_ready
//   is low until it ends. Throughput: one simple transaction per cycle while
//   the output register is free. Reset: synchronous active-low rst_n clears
//   the count and control; keys are not cleared.
// ----------------------------------------------------------------------------
// deque_with_search: double-ended queue of 32-bit keys with a search
// A chain of cells shifts on left pushes and pops; a finder scans the cell
// hit flags for searches and for the right end on right pops.
// ----------------------------------------------------------------------------
module deque_with_search (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [dws_pkg::CMD_W-1:0] in_cmd,
  input  logic signed [dws_pkg::KEY_W-1:0] in_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [dws_pkg::STS_W-1:0] out_status,
  output logic signed [dws_pkg::KEY_W-1:0] out_popped,
  output logic [dws_pkg::POS_W-1:0] out_position,
  output logic [dws_pkg::OCC_W-1:0] out_occupancy
);
  import dws_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic             out_valid_r, out_valid_nxt;
  sts_t             out_status_r, out_status_nxt;
  logic [KEY_W-1:0] out_popped_r, out_popped_nxt;
  logic [CNT_W-1:0] out_pos_r, out_pos_nxt;
  logic [CNT_W-1:0] out_occ_r, out_occ_nxt;
  sts_t             pend_status_r, pend_status_nxt;
  logic [KEY_W-1:0] pend_popped_r, pend_popped_nxt;
  logic [CNT_W-1:0] pend_pos_r, pend_pos_nxt;
  logic [CNT_W-1:0] pend_occ_r, pend_occ_nxt;

  cell_ctrl_t       cctrl;
  fnd_ctrl_t        fctrl;
  fnd_res_t         fres;
  logic [KEY_W-1:0] vals [DEPTH];
  logic [DEPTH-1:0] hits;

  logic             acc;
  logic             out_free;
  logic             full;
  logic             empty;
  logic             res_valid;
  sts_t             res_status;
  logic [KEY_W-1:0] res_popped;
  logic [CNT_W-1:0] res_pos;

  assign in_ready = (state_r == S_IDLE);
  assign acc      = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);

  dws_chain u_chain (
    .clk     (clk),
    .ctrl    (cctrl),
    .cnt     (cnt_r),
    .key     (in_value),
    .cmp_key (key_r),
    .vals    (vals),
    .hits    (hits)
  );

  dws_finder u_finder (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (fctrl),
    .vals  (vals),
    .hits  (hits),
    .res   (fres)
  );

  // Sequence transactions and build results
  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    cmd_nxt         = cmd_r;
    key_nxt         = key_r;
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_popped_nxt  = out_popped_r;
    out_pos_nxt     = out_pos_r;
    out_occ_nxt     = out_occ_r;
    pend_status_nxt = pend_status_r;
    pend_popped_nxt = pend_popped_r;
    pend_pos_nxt    = pend_pos_r;
    pend_occ_nxt    = pend_occ_r;
    cctrl           = '0;
    fctrl           = '0;
    res_valid       = 1'b0;
    res_status      = STS_OK;
    res_popped      = '0;
    res_pos         = '0;

    // Drop the delivered result
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (cmd_t'(in_cmd))
            CMD_PUSH_L, CMD_PUSH_R: begin
              res_valid = 1'b1;
              if (full) begin
                res_status = STS_FULL;
              end else begin
                cctrl.push_l = (cmd_t'(in_cmd) == CMD_PUSH_L);
                cctrl.push_r = (cmd_t'(in_cmd) == CMD_PUSH_R);
                cnt_nxt      = cnt_r + 1'b1;
              end
            end
            CMD_POP_L: begin
              res_valid = 1'b1;
              if (empty) begin
                res_status = STS_EMPTY;
              end else begin
                res_popped  = vals[0];
                cctrl.pop_l = 1'b1;
                cnt_nxt     = cnt_r - 1'b1;
              end
            end
            CMD_POP_R: begin
              if (empty) begin
                res_valid  = 1'b1;
                res_status = STS_EMPTY;
              end else begin
                cmd_nxt   = CMD_POP_R;
                state_nxt = S_CMP;
              end
            end
            CMD_SEARCH: begin
              cmd_nxt   = CMD_SEARCH;
              key_nxt   = in_value;
              state_nxt = S_CMP;
            end
            default: begin
              res_valid = 1'b1;
            end
          endcase
        end
      end
      S_CMP: begin
        cctrl.hit_load = 1'b1;
        cctrl.hit_srch = (cmd_r == CMD_SEARCH);
        fctrl.clr      = 1'b1;
        state_nxt      = S_SCAN;
      end
      S_SCAN: begin
        fctrl.step = 1'b1;
        if (fres.done) begin
          res_valid = 1'b1;
          if (cmd_r == CMD_POP_R) begin
            res_popped = fres.val;
            cnt_nxt    = cnt_r - 1'b1;
          end else begin
            res_pos = fres.pos;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pend_status_r;
          out_popped_nxt = pend_popped_r;
          out_pos_nxt    = pend_pos_r;
          out_occ_nxt    = pend_occ_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Hand the result to the output register, or hold it until free
    if (res_valid) begin
      if (out_free) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = res_status;
        out_popped_nxt = res_popped;
        out_pos_nxt    = res_pos;
        out_occ_nxt    = cnt_nxt;
        state_nxt      = S_IDLE;
      end else begin
        pend_status_nxt = res_status;
        pend_popped_nxt = res_popped;
        pend_pos_nxt    = res_pos;
        pend_occ_nxt    = cnt_nxt;
        state_nxt       = S_DONE;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    key_r         <= key_nxt;
    out_status_r  <= out_status_nxt;
    out_popped_r  <= out_popped_nxt;
    out_pos_r     <= out_pos_nxt;
    out_occ_r     <= out_occ_nxt;
    pend_status_r <= pend_status_nxt;
    pend_popped_r <= pend_popped_nxt;
    pend_pos_r    <= pend_pos_nxt;
    pend_occ_r    <= pend_occ_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_popped    = $signed(out_popped_r);
  assign out_position  = POS_W'(out_pos_r);
  assign out_occupancy = OCC_W'(out_occ_r);

endmodule

/* bench/deque_with_search_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_with_search_tb: self-checking bench for the deque with search
// Walks a short table of directed operations, then random fill and drain
// sequences with searches. The receiver holds off once for a long stretch.
// Results are checked field by field against table rows or a behavioral deque.
// ----------------------------------------------------------------------------
module deque_with_search_tb;
  import dws_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED_5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;
  localparam int RANDOM_OPS  = 500;
  localparam int HOLD_CYCLES = 300;
  localparam int PRESSURE_OPS = 40;
  localparam int CALM_OPS    = 80;
  localparam int DRAIN_WAIT  = 20;

  typedef struct packed {
    sts_t                    status;
    logic signed [KEY_W-1:0] popped;
    logic [POS_W-1:0]        position;
    logic [OCC_W-1:0]        occupancy;
  } deque_result_t;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic signed [KEY_W-1:0] value;
    logic                    typed;
    deque_result_t           want;
  } op_row_t;

  localparam logic signed [KEY_W-1:0] KMAX = 32'sh7FFF_FFFF;
  localparam logic signed [KEY_W-1:0] KMIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KNEG = 32'shFFFF_FFFF;
  localparam logic signed [KEY_W-1:0] KZERO = 32'sh0;

  // Directed operations; typed rows carry their result, others use the predictor
  localparam int DIR_N = 22;
  op_row_t dir_ops [DIR_N] = '{
    '{CMD_POP_L,    KZERO, 1'b1, '{STS_EMPTY, KZERO, 7'd0, 7'd0}},
    '{CMD_POP_R,    KZERO, 1'b1, '{STS_EMPTY, KZERO, 7'd0, 7'd0}},
    '{CMD_SEARCH,   KZERO, 1'b1, '{STS_OK,    KZERO, 7'd0, 7'd0}},
    '{CMD_PUSH_R,   KMAX,  1'b1, '{STS_OK,    KZERO, 7'd0, 7'd1}},
    '{CMD_PUSH_L,   KMIN,  1'b1, '{STS_OK,    KZERO, 7'd0, 7'd2}},
    '{CMD_PUSH_R,   KZERO, 1'b1, '{STS_OK,    KZERO, 7'd0, 7'd3}},
    '{CMD_PUSH_L,   KNEG,  1'b1, '{STS_OK,    KZERO, 7'd0, 7'd4}},
    '{CMD_SEARCH,   KMAX,  1'b1, '{STS_OK,    KZERO, 7'd3, 7'd4}},
    '{CMD_SEARCH,   KMIN,  1'b1, '{STS_OK,    KZERO, 7'd2, 7'd4}},
    '{CMD_SEARCH,   32'sd12345, 1'b1, '{STS_OK, KZERO, 7'd0, 7'd4}},
    '{CMD_PUSH_R,   KNEG,  1'b1, '{STS_OK,    KZERO, 7'd0, 7'd5}},
    '{CMD_SEARCH,   KNEG,  1'b1, '{STS_OK,    KZERO, 7'd1, 7'd5}},
    '{CMD_UNUSED_5, KMAX,  1'b1, '{STS_OK,    KZERO, 7'd0, 7'd5}},
    '{CMD_UNUSED_6, KNEG,  1'b0, '{STS_OK,    KZERO, 7'd0, 7'd0}},
    '{CMD_UNUSED_7, KMIN,  1'b0, '{STS_OK,    KZERO, 7'd0, 7'd0}},
    '{CMD_POP_R,    KZERO, 1'b1, '{STS_OK,    KNEG,  7'd0, 7'd4}},
    '{CMD_POP_L,    KMAX,  1'b1, '{STS_OK,    KNEG,  7'd0, 7'd3}},
    '{CMD_POP_L,    KZERO, 1'b1, '{STS_OK,    KMIN,  7'd0, 7'd2}},
    '{CMD_POP_R,    KZERO, 1'b1, '{STS_OK,    KZERO, 7'd0, 7'd1}},
    '{CMD_POP_R,    KNEG,  1'b1, '{STS_OK,    KMAX,  7'd0, 7'd0}},
    '{CMD_POP_L,    KZERO, 1'b1, '{STS_EMPTY, KZERO, 7'd0, 7'd0}},
    '{CMD_SEARCH,   KMAX,  1'b1, '{STS_OK,    KZERO, 7'd0, 7'd0}}
  };

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic [CMD_W-1:0]        in_cmd;
  logic signed [KEY_W-1:0] in_value;
  logic                    out_valid;
  logic                    out_ready;
  logic [STS_W-1:0]        out_status;
  logic signed [KEY_W-1:0] out_popped;
  logic [POS_W-1:0]        out_position;
  logic [OCC_W-1:0]        out_occupancy;

  // Behavioral deque state, leftmost key in slot 0
  logic [KEY_W-1:0] held_keys [DEPTH];
  int               held_count;

  deque_result_t pending_results [$];
  int  fail_count;
  int  results_seen;
  int  full_refusals;
  int  empty_pops;
  int  search_hits;
  int  peak_count;
  bit  sender_calm;
  bit  receiver_calm;
  bit  hold_req;
  bit  filling;

  deque_with_search dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_popped   (out_popped),
    .out_position (out_position),
    .out_occupancy(out_occupancy)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("Timeout: %0d results still pending", pending_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Apply one operation to the behavioral deque and return its result
  function automatic deque_result_t apply_deque_op(logic [CMD_W-1:0] cmd,
                                                   logic [KEY_W-1:0] key);
    deque_result_t r;
    r.status    = STS_OK;
    r.popped    = '0;
    r.position  = '0;
    r.occupancy = '0;
    case (cmd)
      CMD_PUSH_L, CMD_PUSH_R: begin
        if (held_count >= DEPTH) begin
          r.status = STS_FULL;
        end else if (cmd == CMD_PUSH_L) begin
          for (int i = held_count; i > 0; i--) held_keys[i] = held_keys[i-1];
          held_keys[0] = key;
          held_count++;
        end else begin
          held_keys[held_count] = key;
          held_count++;
        end
      end
      CMD_POP_L, CMD_POP_R: begin
        if (held_count == 0) begin
          r.status = STS_EMPTY;
        end else if (cmd == CMD_POP_L) begin
          r.popped = held_keys[0];
          for (int i = 0; i + 1 < held_count; i++) held_keys[i] = held_keys[i+1];
          held_count--;
        end else begin
          r.popped = held_keys[held_count-1];
          held_count--;
        end
      end
      CMD_SEARCH: begin
        for (int i = 0; i < held_count; i++)
          if (r.position == 0 && held_keys[i] == key) r.position = POS_W'(i + 1);
      end
      default: ;
    endcase
    r.occupancy = OCC_W'(held_count);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [KEY_W-1:0] got,
                                 logic [KEY_W-1:0] want);
    $display("ERROR @%0t result %0d: %s got %0h want %0h",
             $realtime, results_seen, what, got, want);
    fail_count++;
  endtask

  // Offer one transaction, hold it until taken, then log its expected result
  task automatic send_op(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                         logic typed, deque_result_t want);
    deque_result_t got;
    if (!sender_calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_value <= key;
    do @(posedge clk); while (!in_ready);
    got = apply_deque_op(cmd, key);
    pending_results.push_back(typed ? want : got);
    if (got.status == STS_FULL) full_refusals++;
    if (got.status == STS_EMPTY) empty_pops++;
    if (got.position != 0) search_hits++;
    if (held_count > peak_count) peak_count = held_count;
  endtask

  // Favor held keys for searches; mix in extremes and a small pool for duplicates
  function automatic logic [KEY_W-1:0] pick_key(bit for_search);
    if (for_search && held_count > 0 && $urandom_range(0, 1) == 1)
      return held_keys[$urandom_range(0, held_count - 1)];
    case ($urandom_range(0, 3))
      0:       return KEY_W'($urandom_range(0, 7)) - 32'd4;
      1:       return ($urandom_range(0, 1) == 1) ? KMAX : KMIN;
      default: return $urandom();
    endcase
  endfunction

  // Bias toward pushes while filling and toward pops while draining
  function automatic logic [CMD_W-1:0] pick_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r >= 96) return CMD_W'($urandom_range(CMD_UNUSED_5, CMD_UNUSED_7));
    if (r >= 80) return CMD_SEARCH;
    if (filling) begin
      if (r < 30) return CMD_PUSH_L;
      if (r < 60) return CMD_PUSH_R;
      return (r < 70) ? CMD_POP_L : CMD_POP_R;
    end
    if (r < 10) return CMD_PUSH_L;
    if (r < 20) return CMD_PUSH_R;
    return (r < 50) ? CMD_POP_L : CMD_POP_R;
  endfunction

  task automatic send_random_op();
    logic [CMD_W-1:0] cmd;
    deque_result_t    none;
    none = '0;
    if (filling && held_count == DEPTH && $urandom_range(0, 3) == 0) filling = 1'b0;
    if (!filling && held_count == 0 && $urandom_range(0, 3) == 0) filling = 1'b1;
    cmd = pick_cmd();
    send_op(cmd, pick_key(cmd == CMD_SEARCH), 1'b0, none);
  endtask

  // Result side: stall in random bursts, or hold off for a long stretch on request
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (receiver_calm || $urandom_range(0, 3) != 0) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  end

  // Compare each returned transaction against the oldest expectation
  always @(posedge clk) begin : result_check
    deque_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", KEY_W'(out_status), '0);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", KEY_W'(out_status), KEY_W'(want.status));
        if (out_popped !== want.popped) report_mismatch("popped", out_popped, want.popped);
        if (out_position !== want.position)
          report_mismatch("position", KEY_W'(out_position), KEY_W'(want.position));
        if (out_occupancy !== want.occupancy)
          report_mismatch("occupancy", KEY_W'(out_occupancy), KEY_W'(want.occupancy));
      end
      results_seen++;
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_cmd        = '0;
    in_value      = '0;
    fail_count    = 0;
    results_seen  = 0;
    full_refusals = 0;
    empty_pops    = 0;
    search_hits   = 0;
    peak_count    = 0;
    held_count    = 0;
    sender_calm   = 1'b0;
    receiver_calm = 1'b0;
    hold_req      = 1'b0;
    filling       = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    for (int i = 0; i < DIR_N; i++)
      send_op(dir_ops[i].cmd, dir_ops[i].value, dir_ops[i].typed, dir_ops[i].want);

    // Random fill and drain sequences with idling on both sides
    for (int i = 0; i < RANDOM_OPS - PRESSURE_OPS - CALM_OPS; i++) begin
      if (i == (RANDOM_OPS - PRESSURE_OPS - CALM_OPS) / 2) begin
        // Hold the result side off and keep offering so the block backs up
        hold_req    = 1'b1;
        sender_calm = 1'b1;
        for (int j = 0; j < PRESSURE_OPS; j++) send_random_op();
        sender_calm = 1'b0;
      end
      send_random_op();
    end

    // Finish without idling on either side
    sender_calm   = 1'b1;
    receiver_calm = 1'b1;
    for (int i = 0; i < CALM_OPS; i++) send_random_op();
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Checked %0d results: %0d refused pushes, %0d pops on empty, %0d search hits",
             results_seen, full_refusals, empty_pops, search_hits);
    $display("Peak occupancy %0d of %0d, %0d field mismatches",
             peak_count, DEPTH, fail_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
